// File: sv/dsh_pkg.sv
// ----------------------------------------------------------------------------
// dsh_pkg
// Shared constants, field widths and codes of the deadband sample history.
// ----------------------------------------------------------------------------
`default_nettype none

package dsh_pkg;

    // History ring storage; depth must stay a power of two for ring wrap
    localparam int HISTORY_DEPTH = 32;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int COUNT_W       = $clog2(HISTORY_DEPTH + 1);

    // Deepest difference test
    localparam int MAX_COMPARE   = 8;
    localparam int CMP_W         = $clog2(MAX_COMPARE + 1);

    // Field widths
    localparam int TIME_W        = 32;
    localparam int VALUE_W       = 24;
    localparam int STEP_W        = 23;
    localparam int DEPTH_W       = 4;
    localparam int INDEX_W       = 5;
    localparam int STATUS_W      = 3;
    localparam int DIFF_W        = VALUE_W + 1;
    localparam int THR_W         = STEP_W + CMP_W;
    localparam int ENTRY_W       = TIME_W + VALUE_W;

    // Stream payload widths
    localparam int S_TDATA_W     = 64;
    localparam int M_TDATA_W     = 64;

    // Configuration port
    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 32;

    localparam logic [1:0] REG_MIN_TIMESTAMP = 2'd0;
    localparam logic [1:0] REG_MAX_GAP       = 2'd1;
    localparam logic [1:0] REG_IGNORED_STEP  = 2'd2;
    localparam logic [1:0] REG_COMPARE_DEPTH = 2'd3;

    localparam logic [TIME_W-1:0]  MIN_TIMESTAMP_RST = 32'd0;
    localparam logic [TIME_W-1:0]  MAX_GAP_RST       = 32'd3600;
    localparam logic [STEP_W-1:0]  IGNORED_STEP_RST  = 23'd10;
    localparam logic [DEPTH_W-1:0] COMPARE_DEPTH_RST = 4'd3;

    // Commands
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REPLACED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_READ_MISS = 3'd5;

endpackage

`default_nettype wire

// File: sv/dsh_ram.sv
// ----------------------------------------------------------------------------
// dsh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/deadband_sample_history.sv
// Every item passes S_START; a read that hits then S_RDATA and S_DONE, a miss or a
// rejected add S_DONE, an add with under two entries held S_WRITE and S_DONE, else
// S_GAP, S_SCAN with one RAM read per entry compared (0 to 8), S_WRITE and S_DONE.
// Throughput: one item at a time; the next beat is taken the cycle after the
// result is parked in the output register, and a stalled result holds input.
// Reset: config returns to defaults, the history is empty; the RAM is not cleared.
// ----------------------------------------------------------------------------
// deadband_sample_history
// Bounded ring of timestamped samples with deadband compression and readback.
// ----------------------------------------------------------------------------
`default_nettype none

module deadband_sample_history (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // sample_time[31:0], sample_value[55:32], read_index[60:56], zero pad
    input  wire logic [dsh_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd[0]
    input  wire logic                          s_tuser,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // entry_count[5:0], entry_time[37:6], entry_value[61:38], zero pad
    output logic      [dsh_pkg::M_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic      [dsh_pkg::STATUS_W-1:0]  m_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dsh_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [dsh_pkg::PDATA_W-1:0]   pwdata,
    output logic      [dsh_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    import dsh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_GAP,
        S_SCAN,
        S_RDATA,
        S_WRITE,
        S_DONE
    } state_t;

    state_t                      state_reg;

    // Configuration
    logic [TIME_W-1:0]           min_ts_reg;
    logic [TIME_W-1:0]           max_gap_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [DEPTH_W-1:0]          depth_reg;

    // History bookkeeping
    logic [ADDR_W-1:0]           oldest_reg;
    logic [COUNT_W-1:0]          held_reg;

    // Latched input beat
    logic                        in_cmd_reg;
    logic [TIME_W-1:0]           in_time_reg;
    logic signed [VALUE_W-1:0]   in_value_reg;
    logic [INDEX_W-1:0]          in_index_reg;

    // Scan state
    logic [CMP_W-1:0]            cmp_idx_reg;
    logic [THR_W-1:0]            thr_reg;
    logic                        replace_reg;

    // Pending result and output register
    logic [STATUS_W-1:0]         res_status_reg;
    logic [TIME_W-1:0]           res_time_reg;
    logic [VALUE_W-1:0]          res_value_reg;
    logic                        m_tvalid_reg;
    logic [STATUS_W-1:0]         m_status_reg;
    logic [COUNT_W-1:0]          m_count_reg;
    logic [TIME_W-1:0]           m_time_reg;
    logic [VALUE_W-1:0]          m_value_reg;

    // RAM port
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [ENTRY_W-1:0]          ram_rdata;
    logic [TIME_W-1:0]           rd_time;
    logic signed [VALUE_W-1:0]   rd_value;

    // Datapath helpers
    logic                        cfg_write;
    logic [CMP_W-1:0]            depth_eff;
    logic [ADDR_W-1:0]           newest1_slot;
    logic [ADDR_W-1:0]           newest2_slot;
    logic [ADDR_W-1:0]           scan_next_slot;
    logic [ADDR_W-1:0]           tail_slot;
    logic [ADDR_W-1:0]           read_slot;
    logic [TIME_W-1:0]           gap;
    logic signed [DIFF_W-1:0]    diff;
    logic [DIFF_W-1:0]           abs_diff;
    logic                        diff_hit;
    logic                        scan_last;
    logic                        read_hit;
    logic                        out_free;

    assign rd_time  = ram_rdata[ENTRY_W-1:VALUE_W];
    assign rd_value = ram_rdata[VALUE_W-1:0];

    // Ring slots; the held count wraps with the ring at full depth
    assign tail_slot      = oldest_reg + held_reg[ADDR_W-1:0];
    assign newest1_slot   = tail_slot - ADDR_W'(1);
    assign newest2_slot   = tail_slot - ADDR_W'(2);
    assign scan_next_slot = tail_slot - ADDR_W'(cmp_idx_reg) - ADDR_W'(1);
    assign read_slot      = oldest_reg + ADDR_W'(in_index_reg);

    assign depth_eff = (32'(depth_reg) > 32'(MAX_COMPARE)) ? CMP_W'(MAX_COMPARE)
                                                            : CMP_W'(depth_reg);

    assign gap      = in_time_reg - rd_time;
    assign diff     = DIFF_W'(in_value_reg) - DIFF_W'(rd_value);
    assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign diff_hit = 32'(abs_diff) >= 32'(thr_reg);
    assign scan_last = (cmp_idx_reg == depth_eff)
                    || (COUNT_W'(cmp_idx_reg) == held_reg);
    assign read_hit = COUNT_W'(in_index_reg) < held_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = tail_slot;
        ram_raddr = newest1_slot;
        case (state_reg)
            S_START:
            begin
                ram_raddr = (in_cmd_reg == CMD_READ) ? read_slot : newest2_slot;
            end
            S_GAP:
            begin
                ram_raddr = newest1_slot;
            end
            S_SCAN:
            begin
                ram_raddr = scan_next_slot;
            end
            S_WRITE:
            begin
                ram_we = 1'b1;
                if (replace_reg)
                begin
                    ram_waddr = newest1_slot;
                end
                else if (held_reg < COUNT_W'(HISTORY_DEPTH))
                begin
                    ram_waddr = tail_slot;
                end
                else
                begin
                    ram_waddr = oldest_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    dsh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_time_reg, in_value_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            REG_MIN_TIMESTAMP: prdata = min_ts_reg;
            REG_MAX_GAP:       prdata = max_gap_reg;
            REG_IGNORED_STEP:  prdata = PDATA_W'(step_reg);
            REG_COMPARE_DEPTH: prdata = PDATA_W'(depth_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_ts_reg  <= MIN_TIMESTAMP_RST;
            max_gap_reg <= MAX_GAP_RST;
            step_reg    <= IGNORED_STEP_RST;
            depth_reg   <= COMPARE_DEPTH_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_MIN_TIMESTAMP: min_ts_reg  <= pwdata;
                REG_MAX_GAP:       max_gap_reg <= pwdata;
                REG_IGNORED_STEP:  step_reg    <= pwdata[STEP_W-1:0];
                REG_COMPARE_DEPTH: depth_reg   <= pwdata[DEPTH_W-1:0];
                default:           min_ts_reg  <= min_ts_reg;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            oldest_reg     <= '0;
            held_reg       <= '0;
            in_cmd_reg     <= CMD_ADD;
            in_time_reg    <= '0;
            in_value_reg   <= '0;
            in_index_reg   <= '0;
            cmp_idx_reg    <= '0;
            thr_reg        <= '0;
            replace_reg    <= 1'b0;
            res_status_reg <= ST_REJECTED;
            res_time_reg   <= '0;
            res_value_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
            m_status_reg   <= ST_REJECTED;
            m_count_reg    <= '0;
            m_time_reg     <= '0;
            m_value_reg    <= '0;
        end
        else
        begin
            // S_DONE reloads the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        in_cmd_reg   <= s_tuser;
                        in_time_reg  <= s_tdata[31:0];
                        in_value_reg <= s_tdata[55:32];
                        in_index_reg <= s_tdata[60:56];
                        state_reg    <= S_START;
                    end
                end
                S_START:
                begin
                    res_time_reg  <= '0;
                    res_value_reg <= '0;
                    if (in_cmd_reg == CMD_READ)
                    begin
                        if (read_hit)
                        begin
                            state_reg <= S_RDATA;
                        end
                        else
                        begin
                            res_status_reg <= ST_READ_MISS;
                            state_reg      <= S_DONE;
                        end
                    end
                    else if (in_time_reg < min_ts_reg)
                    begin
                        res_status_reg <= ST_REJECTED;
                        state_reg      <= S_DONE;
                    end
                    else if (held_reg < COUNT_W'(2))
                    begin
                        replace_reg <= 1'b0;
                        state_reg   <= S_WRITE;
                    end
                    else
                    begin
                        state_reg <= S_GAP;
                    end
                end
                S_GAP:
                begin
                    // RAM holds the second-newest entry; newest is being fetched
                    cmp_idx_reg <= CMP_W'(1);
                    thr_reg     <= THR_W'(step_reg);
                    if (gap >= max_gap_reg)
                    begin
                        replace_reg <= 1'b0;
                        state_reg   <= S_WRITE;
                    end
                    else if (depth_eff == '0)
                    begin
                        replace_reg <= 1'b1;
                        state_reg   <= S_WRITE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (diff_hit)
                    begin
                        replace_reg <= 1'b0;
                        state_reg   <= S_WRITE;
                    end
                    else if (scan_last)
                    begin
                        replace_reg <= 1'b1;
                        state_reg   <= S_WRITE;
                    end
                    else
                    begin
                        cmp_idx_reg <= cmp_idx_reg + CMP_W'(1);
                        thr_reg     <= thr_reg + THR_W'(step_reg);
                    end
                end
                S_RDATA:
                begin
                    res_status_reg <= ST_READ_OK;
                    res_time_reg   <= rd_time;
                    res_value_reg  <= rd_value;
                    state_reg      <= S_DONE;
                end
                S_WRITE:
                begin
                    if (replace_reg)
                    begin
                        res_status_reg <= ST_REPLACED;
                    end
                    else if (held_reg < COUNT_W'(HISTORY_DEPTH))
                    begin
                        held_reg       <= held_reg + COUNT_W'(1);
                        res_status_reg <= ST_APPENDED;
                    end
                    else
                    begin
                        // Drop the oldest entry to make room
                        oldest_reg     <= oldest_reg + ADDR_W'(1);
                        res_status_reg <= ST_DROPPED;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_count_reg  <= held_reg;
                        m_time_reg   <= res_time_reg;
                        m_value_reg  <= res_value_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(M_TDATA_W - COUNT_W - TIME_W - VALUE_W){1'b0}},
                       m_value_reg, m_time_reg, m_count_reg};

endmodule

`default_nettype wire

// File: sv/dsh_checker.sv
// ----------------------------------------------------------------------------
// dsh_checker
// Port-level checks of the deadband sample history, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dsh_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [dsh_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [dsh_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic [dsh_pkg::STATUS_W-1:0]  m_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dsh_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [dsh_pkg::PDATA_W-1:0]   pwdata,
    input  wire logic [dsh_pkg::PDATA_W-1:0]   prdata,
    input  wire logic                          pready
);

    import dsh_pkg::*;

    // Held result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // One item in flight: no input beat right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second input beat taken while busy");

    // Only a successful read carries entry data
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_READ_OK) |-> m_tdata[61:6] == '0)
        else $error("entry fields not zero on non-read result");

    // Count never exceeds depth, status is a defined code
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[5:0]) <= 32'(HISTORY_DEPTH))
                     && (m_tuser <= ST_READ_MISS))
        else $error("result count or status out of range");

    // A result beat only rises while an item is in flight
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result beat without item in flight");

endmodule

bind deadband_sample_history dsh_checker u_dsh_checker (.*);

`default_nettype wire

// File: verif/tb_deadband_sample_history.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadband_sample_history
// Drives add and read commands through the sample stream and checks every
// reply against a cycle-free tracker of the history ring, across several
// register settings, with random stalls on both stream sides.
// ----------------------------------------------------------------------------

module tb_deadband_sample_history;

    import dsh_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic [TIME_W-1:0]   etime;
        logic [VALUE_W-1:0]  evalue;
    } reply_t;

    // Tracks the history ring and holds the replies still owed by the block
    class history_ledger;
        logic [TIME_W-1:0]         slot_time [HISTORY_DEPTH];
        logic signed [VALUE_W-1:0] slot_value [HISTORY_DEPTH];
        int unsigned               oldest;
        int unsigned               held;
        logic [TIME_W-1:0]         min_ts;
        logic [TIME_W-1:0]         max_gap;
        logic [STEP_W-1:0]         step;
        logic [DEPTH_W-1:0]        cmp_depth;
        reply_t                    due_replies[$];
        int                        errors;

        function new();
            oldest    = 0;
            held      = 0;
            min_ts    = MIN_TIMESTAMP_RST;
            max_gap   = MAX_GAP_RST;
            step      = IGNORED_STEP_RST;
            cmp_depth = COMPARE_DEPTH_RST;
            errors    = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [PDATA_W-1:0] val);
            case (idx)
                REG_MIN_TIMESTAMP: min_ts    = val;
                REG_MAX_GAP:       max_gap   = val;
                REG_IGNORED_STEP:  step      = val[STEP_W-1:0];
                REG_COMPARE_DEPTH: cmp_depth = val[DEPTH_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [PDATA_W-1:0] register_value(logic [1:0] idx);
            case (idx)
                REG_MIN_TIMESTAMP: return min_ts;
                REG_MAX_GAP:       return max_gap;
                REG_IGNORED_STEP:  return PDATA_W'(step);
                default:           return PDATA_W'(cmp_depth);
            endcase
        endfunction

        function int unsigned pending();
            return due_replies.size();
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        endfunction

        // ring slot of the i-th newest entry
        function int unsigned newest(int unsigned i);
            return (oldest + held - i) % HISTORY_DEPTH;
        endfunction

        function bit wants_append(logic [TIME_W-1:0] t, logic signed [VALUE_W-1:0] v);
            logic [TIME_W-1:0] dt;
            int                lim;
            int                d;
            if (held < 2)
                return 1;
            dt = t - slot_time[newest(2)];
            if (dt >= max_gap)
                return 1;
            lim = (cmp_depth > MAX_COMPARE) ? MAX_COMPARE : int'(cmp_depth);
            for (int i = 1; i <= lim && i <= held; i++)
            begin
                d = int'(v) - int'(slot_value[newest(i)]);
                if (d < 0)
                    d = -d;
                if (d >= int'(step) * i)
                    return 1;
            end
            return 0;
        endfunction

        function void take_command(logic cmd, logic [TIME_W-1:0] t,
                                   logic signed [VALUE_W-1:0] v, logic [INDEX_W-1:0] idx);
            reply_t      r;
            int unsigned s;
            r = '0;
            if (cmd == CMD_ADD)
            begin
                if (t < min_ts)
                    r.status = ST_REJECTED;
                else
                begin
                    if (!wants_append(t, v))
                    begin
                        s = newest(1);
                        r.status = ST_REPLACED;
                    end
                    else if (held < HISTORY_DEPTH)
                    begin
                        s = (oldest + held) % HISTORY_DEPTH;
                        held++;
                        r.status = ST_APPENDED;
                    end
                    else
                    begin
                        s = oldest;
                        oldest = (oldest + 1) % HISTORY_DEPTH;
                        r.status = ST_DROPPED;
                    end
                    slot_time[s]  = t;
                    slot_value[s] = v;
                end
            end
            else if (idx < held)
            begin
                s = (oldest + idx) % HISTORY_DEPTH;
                r.etime  = slot_time[s];
                r.evalue = slot_value[s];
                r.status = ST_READ_OK;
            end
            else
                r.status = ST_READ_MISS;
            r.count = COUNT_W'(held);
            due_replies.push_back(r);
        endfunction

        function void match_reply(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count,
                                  logic [TIME_W-1:0] etime, logic [VALUE_W-1:0] evalue);
            reply_t want;
            if (due_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply, expected none actual status %h count %h",
                         $time, status, count);
                return;
            end
            want = due_replies.pop_front();
            if (status !== want.status)
                flag("status", 32'(want.status), 32'(status));
            if (count !== want.count)
                flag("entry_count", 32'(want.count), 32'(count));
            if (etime !== want.etime)
                flag("entry_time", want.etime, etime);
            if (evalue !== want.evalue)
                flag("entry_value", 32'(want.evalue), 32'(evalue));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    history_ledger             book = new();
    int                        tx_idle_pct;
    int                        rx_idle_pct;
    int                        rx_hold_len;
    int                        cycle_count;
    logic [TIME_W-1:0]         stim_time;
    logic signed [VALUE_W-1:0] stim_value;

    deadband_sample_history i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The limit sits far above the worst case per item plus stalls on both sides,
    // for about 1700 items and one long hold.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold while rx_hold_len runs down
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_len > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_len--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            book.match_reply(m_tuser, m_tdata[5:0], m_tdata[37:6], m_tdata[61:38]);
        if (rst_n && s_tvalid && s_tready)
            book.take_command(s_tuser, s_tdata[31:0], s_tdata[55:32], s_tdata[60:56]);
    end

    task automatic send_item(logic cmd, logic [TIME_W-1:0] t,
                             logic signed [VALUE_W-1:0] v, logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, idx, v, t};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drop valid and hold until every owed reply has arrived
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] back;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        book.set_register(idx, val);
        // read back through the same port
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        back = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (back !== book.register_value(idx))
            book.flag("register readback", book.register_value(idx), back);
    endtask

    task automatic apply_settings(logic [31:0] min_ts, logic [31:0] gap,
                                  logic [31:0] step, logic [31:0] depth);
        wait_drained();
        write_register(REG_MIN_TIMESTAMP, min_ts);
        write_register(REG_MAX_GAP, gap);
        write_register(REG_IGNORED_STEP, step);
        write_register(REG_COMPARE_DEPTH, depth);
    endtask

    // Mostly a slowly drifting sensor trace, with reads, boundary times and noise
    task automatic send_random(int count, int tinc, int vspan);
        int          r;
        int          off;
        logic [31:0] t;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            if (r < 25)
            begin
                if ($urandom_range(3) == 0)
                    send_item(CMD_READ, $urandom, VALUE_W'($urandom),
                              INDEX_W'($urandom_range(31)));
                else
                    send_item(CMD_READ, $urandom, VALUE_W'($urandom),
                              INDEX_W'($urandom_range(book.held)));
            end
            else if (r < 33)
                send_item(CMD_ADD, $urandom, VALUE_W'($urandom), INDEX_W'($urandom));
            else if (r < 38)
            begin
                case ($urandom_range(3))
                    0: t = 32'h0000_0000;
                    1: t = 32'hFFFF_FFFF;
                    2: t = book.min_ts;
                    default: t = book.min_ts - 1;
                endcase
                send_item(CMD_ADD, t, stim_value, INDEX_W'($urandom));
            end
            else
            begin
                stim_time = stim_time + $urandom_range(tinc);
                if ($urandom_range(15) == 0)
                    stim_value = VALUE_W'($urandom);
                else
                begin
                    off = int'($urandom_range(2 * vspan)) - vspan;
                    stim_value = VALUE_W'(int'(stim_value) + off);
                end
                send_item(CMD_ADD, stim_time, stim_value, INDEX_W'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = CMD_ADD;
        s_tdata     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        rx_hold_len = 0;
        cycle_count = 0;
        stim_time   = 32'd5000;
        stim_value  = '0;
        tx_idle_pct = 22;
        rx_idle_pct = 45;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // empty history, extreme values, replace, gap, time wrap, reads
        send_item(CMD_READ, 32'd0, 24'sd0, 5'd0);
        send_item(CMD_READ, 32'd0, 24'sd0, 5'd31);
        send_item(CMD_ADD, 32'd0, -24'sd8388608, 5'd0);
        send_item(CMD_ADD, 32'd100, 24'sd8388607, 5'd31);
        send_item(CMD_ADD, 32'd200, 24'sd8388607, 5'd0);
        send_item(CMD_ADD, 32'd300, 24'sd8388605, 5'd0);
        send_item(CMD_ADD, 32'd310, 24'sd8388606, 5'd0);
        send_item(CMD_ADD, 32'd3800, 24'sd8388606, 5'd0);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 24'sd0, 5'd0);
        send_item(CMD_ADD, 32'd5, 24'sd1, 5'd0);
        send_item(CMD_ADD, 32'd6, 24'sd2, 5'd0);
        send_item(CMD_ADD, 32'd7, 24'sd3, 5'd0);
        send_item(CMD_READ, 32'd0, 24'sd0, 5'd0);
        send_item(CMD_READ, 32'd0, 24'sd0, 5'd5);
        send_item(CMD_READ, 32'd0, 24'sd0, 5'd6);
        send_item(CMD_READ, 32'd0, 24'sd0, 5'd7);
        send_item(CMD_READ, 32'hFFFF_FFFF, -24'sd1, 5'd31);
        wait_drained();
        write_register(REG_MIN_TIMESTAMP, 32'd1000);
        send_item(CMD_ADD, 32'd999, 24'sd50, 5'd0);
        send_item(CMD_ADD, 32'd1000, 24'sd50, 5'd0);
        send_item(CMD_READ, 32'd0, 24'sd0, 5'd8);

        // defaults: fill the ring, then replace and drop
        apply_settings(32'd0, 32'd3600, 32'd10, 32'd3);
        send_random(300, 1200, 40);

        // huge step and gap: mostly replace; early samples fall under the minimum
        apply_settings(stim_time + 2000, 32'hFFFF_FFFF, 32'h007F_FFFF, 32'd8);
        send_random(100, 50, 40);
        rx_hold_len = 400;
        send_random(150, 50, 40);

        // zero gap forces an append every time
        tx_idle_pct = 45;
        rx_idle_pct = 22;
        apply_settings(32'd0, 32'd0, 32'd0, 32'd0);
        send_random(250, 100, 40);

        // nothing compared and no gap: nearly always replace
        apply_settings(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_random(250, 100, 40);

        // compare depth beyond the deepest test
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_settings(32'd0, 32'd5000, 32'd25, 32'd15);
        send_random(125, 800, 60);
        wait_drained();
        send_random(125, 800, 60);

        // zero step with one entry compared
        apply_settings(32'd0, 32'd20000, 32'd0, 32'd1);
        send_random(250, 500, 40);

        // highest minimum: nearly everything rejected
        apply_settings(32'hFFFF_FFFF, 32'd3600, 32'd10, 32'd3);
        send_random(100, 500, 40);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
